// ----- rtl/psg_pkg.sv -----
`default_nettype none
package psg_pkg;

	localparam int CLK_W   = 24;
	localparam int RATE_W  = 18;
	localparam int PER_W   = 10;
	localparam int PHASE_W = 32;
	localparam int DIVD_W  = PHASE_W + 1;
	localparam int CNT_W   = 29;
	localparam int AMP_W   = 13;
	localparam int SUM_W   = 17;
	localparam int STEP_W  = 6;

	localparam logic [CLK_W-1:0]  CLK_RESET   = 24'd3579545;
	localparam logic [RATE_W-1:0] RATE_RESET  = 18'd44100;
	localparam logic [15:0]       NOISE_SEED  = 16'h8000;
	localparam logic [2:0]        REG_NOISE   = 3'd6;
	localparam logic [2:0]        REG_TONE0   = 3'd0;
	localparam logic [2:0]        REG_TONE1   = 3'd2;
	localparam logic [2:0]        REG_TONE2   = 3'd4;
	localparam logic              CFG_CLOCK   = 1'b0;
	localparam logic              CFG_RATE    = 1'b1;
	localparam logic              CMD_TICK    = 1'b1;
	localparam logic [1:0]        CH_TONE3    = 2'd2;
	localparam logic [1:0]        CH_NOISE    = 2'd3;
	localparam logic [1:0]        MODE_TONE3  = 2'd3;
	localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(DIVD_W - 1);

	typedef struct packed {
		logic       wr;
		logic       load;
		logic       step;
		logic       fin;
		logic       shift;
		logic       out_load;
		logic [1:0] ch;
	} psg_cmd_t;

	typedef struct packed {
		logic noise_skip;
		logic shift_done;
		logic out_free;
	} psg_stat_t;

	// Attenuation step factors in Q16, 2 dB apart, last level silent.
	function automatic logic [16:0] atten_q16(input logic [3:0] a);
		logic [16:0] f;
		case (a)
			4'd0:    f = 17'd65536;
			4'd1:    f = 17'd52057;
			4'd2:    f = 17'd41350;
			4'd3:    f = 17'd32846;
			4'd4:    f = 17'd26090;
			4'd5:    f = 17'd20724;
			4'd6:    f = 17'd16462;
			4'd7:    f = 17'd13076;
			4'd8:    f = 17'd10387;
			4'd9:    f = 17'd8250;
			4'd10:   f = 17'd6554;
			4'd11:   f = 17'd5206;
			4'd12:   f = 17'd4135;
			4'd13:   f = 17'd3285;
			4'd14:   f = 17'd2609;
			default: f = 17'd0;
		endcase
		return f;
	endfunction

	function automatic logic [AMP_W-1:0] amp_calc(input int peak, input logic [3:0] a);
		logic [47:0] v;
		v = 48'(peak) * 48'(atten_q16(a)) + 48'd32768;
		return v[16 +: AMP_W];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/psg_ctrl.sv -----
`default_nettype none
module psg_ctrl
	import psg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      command,
	output logic           in_stall,
	input  wire psg_stat_t stat,
	output psg_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_DIV, S_FIN, S_SHIFT, S_OUT
	} state_t;

	state_t            state_q;
	logic [1:0]        ch_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd          = '0;
		cmd.ch       = ch_q;
		cmd.wr       = accept && (command != CMD_TICK);
		cmd.load     = (state_q == S_LOAD);
		cmd.step     = (state_q == S_DIV);
		cmd.fin      = (state_q == S_FIN);
		cmd.shift    = (state_q == S_SHIFT) && !stat.shift_done;
		cmd.out_load = (state_q == S_OUT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && command == CMD_TICK) begin
						ch_q    <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (ch_q == CH_NOISE || (ch_q == CH_TONE3 && stat.noise_skip)) begin
						state_q <= S_SHIFT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_SHIFT: begin
					if (stat.shift_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/psg_datapath.sv -----
`default_nettype none
module psg_datapath
	import psg_pkg::*;
#(
	parameter int PEAK_AMPLITUDE = 8191
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [CLK_W-1:0]    cfg_data,
	input  wire logic [7:0]          data_byte,
	input  wire psg_cmd_t            cmd,
	output psg_stat_t                stat,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic signed [15:0]       sample
);

	logic [CLK_W-1:0]   clk_hz_q;
	logic [RATE_W-1:0]  rate_q;
	logic [PER_W-1:0]   period_q [3];
	logic [3:0]         atten_q  [4];
	logic [PHASE_W-1:0] phase_q  [3];
	logic [2:0]         level_q;
	logic [PHASE_W-1:0] nphase_q;
	logic [15:0]        shreg_q;
	logic [2:0]         mode_q;
	logic [2:0]         latch_q;
	logic [PHASE_W-1:0] divisor_q;
	logic [PHASE_W-1:0] rem_q;
	logic [DIVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic signed [15:0] sample_q;

	logic [AMP_W-1:0]   amp_tab [16];

	for (genvar i = 0; i < 16; i++) begin : g_amp
		assign amp_tab[i] = amp_calc(PEAK_AMPLITUDE, 4'(i));
	end

	// Period factor and dividend selection.
	logic [RATE_W-1:0]        rate_eff;
	logic [1:0]               tidx;
	logic [PER_W+RATE_W-1:0]  tone_mul;
	logic [PHASE_W-1:0]       div_sel;
	logic [PHASE_W-1:0]       phase_sel;

	assign rate_eff  = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign tidx      = (cmd.ch == CH_NOISE) ? 2'd0 : cmd.ch;
	assign tone_mul  = (PER_W+RATE_W)'(period_q[tidx]) * (PER_W+RATE_W)'(rate_eff);
	assign div_sel   = (cmd.ch == CH_NOISE)
		? (PHASE_W'(rate_eff) << (5'd9 + 5'(mode_q[1:0])))
		: {tone_mul, 4'b0000};
	assign phase_sel = (cmd.ch == CH_NOISE) ? nphase_q : phase_q[tidx];

	// One restoring division step.
	logic [DIVD_W-1:0] trial;
	logic [DIVD_W-1:0] trial_sub;
	logic              trial_ge;

	assign trial     = {rem_q, quo_q[DIVD_W-1]};
	assign trial_ge  = trial >= {1'b0, divisor_q};
	assign trial_sub = trial - {1'b0, divisor_q};

	// Edge count and rising edges of the third tone channel.
	logic [CNT_W-1:0] n;
	logic [CNT_W:0]   n_inc;
	logic [CNT_W-1:0] rising;

	assign n      = quo_q[CNT_W-1:0];
	assign n_inc  = {1'b0, n} + 1'b1;
	assign rising = level_q[CH_TONE3] ? (n >> 1) : n_inc[CNT_W:1];

	// Noise shifter steps.
	logic [15:0] white_one;
	logic [15:0] white_eight;
	logic [31:0] rot_wide;

	always_comb begin
		white_one   = {shreg_q[0] ^ shreg_q[3], shreg_q[15:1]};
		white_eight = shreg_q;
		for (int k = 0; k < 8; k++)
			white_eight = {white_eight[0] ^ white_eight[3], white_eight[15:1]};
	end

	assign rot_wide = {shreg_q, shreg_q} >> cnt_q[3:0];

	// Mixer.
	logic signed [SUM_W-1:0] term [4];
	logic signed [SUM_W-1:0] sum;
	logic [3:0]              hi;

	assign hi = {shreg_q[0], level_q};

	always_comb begin
		for (int c = 0; c < 4; c++)
			term[c] = hi[c] ? SUM_W'(amp_tab[atten_q[c]]) : -SUM_W'(amp_tab[atten_q[c]]);
		sum = term[0] + term[1] + term[2] + term[3];
	end

	logic signed [15:0] clamped;

	always_comb begin
		if (sum > SUM_W'(32767))
			clamped = 16'sh7fff;
		else if (sum < -SUM_W'(32768))
			clamped = 16'sh8000;
		else
			clamped = sum[15:0];
	end

	assign stat.noise_skip = (mode_q[1:0] == MODE_TONE3);
	assign stat.shift_done = (cnt_q == '0);
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign sample          = sample_q;

	logic [2:0]       lr;
	logic [PER_W-1:0] per_new;

	always_comb begin
		lr      = data_byte[7] ? data_byte[6:4] : latch_q;
		if (data_byte[7])
			per_new = {period_q[lr[2:1]][PER_W-1:4], data_byte[3:0]};
		else
			per_new = {data_byte[5:0], period_q[lr[2:1]][3:0]};
		if (per_new == '0)
			per_new = PER_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q    <= CLK_RESET;
			rate_q      <= RATE_RESET;
			for (int c = 0; c < 3; c++) begin
				period_q[c] <= PER_W'(1);
				phase_q[c]  <= '0;
			end
			for (int c = 0; c < 4; c++)
				atten_q[c] <= 4'hf;
			level_q     <= 3'b111;
			nphase_q    <= '0;
			shreg_q     <= NOISE_SEED;
			mode_q      <= '0;
			latch_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_CLOCK)
					clk_hz_q <= cfg_data;
				else
					rate_q <= cfg_data[RATE_W-1:0];
			end
			if (cmd.wr) begin
				latch_q <= lr;
				if (data_byte[7] && lr[0]) begin
					atten_q[lr[2:1]] <= data_byte[3:0];
				end else if (lr == REG_NOISE) begin
					mode_q   <= data_byte[2:0];
					shreg_q  <= NOISE_SEED;
					nphase_q <= '0;
				end else if (lr == REG_TONE0 || lr == REG_TONE1 || lr == REG_TONE2) begin
					period_q[lr[2:1]] <= per_new;
				end else begin
					atten_q[lr[2:1]] <= data_byte[3:0];
				end
			end
			if (cmd.fin) begin
				if (cmd.ch == CH_NOISE) begin
					nphase_q <= rem_q;
					cnt_q    <= n;
				end else begin
					phase_q[tidx] <= rem_q;
					level_q[tidx] <= level_q[tidx] ^ n[0];
					if (cmd.ch == CH_TONE3)
						cnt_q <= rising;
				end
			end
			if (cmd.shift) begin
				if (!mode_q[2]) begin
					shreg_q <= rot_wide[15:0];
					cnt_q   <= '0;
				end else if (cnt_q >= CNT_W'(8)) begin
					shreg_q <= white_eight;
					cnt_q   <= cnt_q - CNT_W'(8);
				end else begin
					shreg_q <= white_one;
					cnt_q   <= cnt_q - 1'b1;
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			divisor_q <= div_sel;
			rem_q     <= '0;
			quo_q     <= {1'b0, phase_sel} + DIVD_W'(clk_hz_q);
		end else if (cmd.step) begin
			rem_q <= trial_ge ? trial_sub[PHASE_W-1:0] : trial[PHASE_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], trial_ge};
		end
		if (cmd.out_load)
			sample_q <= clamped;
	end

endmodule
`default_nettype wire

// ----- rtl/psg_tone_noise_generator.sv -----
// Write transactions give no result.
// A tick transaction runs each tone channel through a load, 33 divide steps and an update,
// then the noise divider the same way unless the noise follows the third tone, then the
// noise shifter: at most one rotate when periodic, steps of one or eight bits when white,
// then the output load, held while an earlier sample is still waiting.
// The shared 33-step restoring divider sets the pace; one transaction is in flight at a time.
// Async active-low reset restores defaults in all but the divider and sample registers.
`default_nettype none
module psg_tone_noise_generator
	import psg_pkg::*;
#(
	parameter int PEAK_AMPLITUDE = 8191
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CLK_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [7:0]         data_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      sample
);

	// The controller sequences each tick through the three tone channels and, unless
	// the noise follows the third tone, the noise channel, reusing one divider, then
	// steps the noise shifter and loads the output register. The output register
	// frees the input side while a finished sample waits to be taken.
	psg_cmd_t  cmd;
	psg_stat_t stat;

	psg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	psg_datapath #(
		.PEAK_AMPLITUDE (PEAK_AMPLITUDE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data_byte (data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sample    (sample)
	);

`ifndef NO_ASSERTIONS
	// A tick transaction always keeps the input side busy in the next cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command |=> in_stall)
		else $error("tick transaction did not occupy the block");

	// A write transaction never creates a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !command && !out_valid |=> !out_valid)
		else $error("write transaction produced a sample");

	// A new sample only appears at the end of a tick, while the input side is busy.
	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("sample appeared without a tick in progress");
`endif

endmodule
`default_nettype wire
